// ===== hdl/score_sort_and_zero_trim_core_macros.svh =====
// ----------------------------------------------------------------------------
// Score sort and zero trim: assertion macros
// Clocked on aclk, held off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef SCORE_SORT_AND_ZERO_TRIM_CORE_MACROS_SVH
`define SCORE_SORT_AND_ZERO_TRIM_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Check a condition at every edge.
`define SSZ_ASSERT(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("ssz assertion failed");
// Check a consequence in the cycle after a trigger.
`define SSZ_ASSERT_NEXT(label, trig, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cons)) \
        else $error("ssz assertion failed");
`else
`define SSZ_ASSERT(label, cond)
`define SSZ_ASSERT_NEXT(label, trig, cons)
`endif

`endif

// ===== hdl/ssz_pkg.sv =====
// ----------------------------------------------------------------------------
// ssz_pkg
// Sizes and shared types of the score sort and zero trim core.
// ----------------------------------------------------------------------------
package ssz_pkg;

    localparam int CAPACITY   = 64;
    localparam int SCORE_BITS = 24;
    localparam int COORD_BITS = 5;
    localparam int CUT_BITS   = 6;
    localparam int FILL_BITS  = $clog2(CAPACITY + 1);

    // One stored point
    typedef struct packed {
        logic [SCORE_BITS-1:0] score;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } ssz_point_t;

    // Chain control, same for every cell
    typedef struct packed {
        logic insert;     // place the new point, push lower ones right
        logic shift_out;  // move every point one cell toward the head
    } ssz_ctrl_t;

endpackage

// ===== hdl/score_sort_and_zero_trim_core.sv =====
// ----------------------------------------------------------------------------
// score_sort_and_zero_trim_core
// Loads a run of points and emits them by descending score, stable on ties,
// with an optional trim of the zero-score tail.
// ----------------------------------------------------------------------------
// A run is taken in at one point per cycle: a chain of 64 cells compares the
// incoming score with every stored one at once and shifts the lower part one
// cell down, so the chain is always sorted. The word with s_last_item closes
// the run; no input is taken while the run is emitted. Emission pops the head
// cell into the output register one word per cycle as long as m_ready is high.
// The next run is taken from the cycle after the final word enters the output
// register. Points beyond 64 are dropped and flag overflow on every word of
// that run; with trim_enable set, the sorted tail from the first zero score
// after the head is dropped and its size is given in cut_count on the final
// word.
// ----------------------------------------------------------------------------
`include "score_sort_and_zero_trim_core_macros.svh"

module score_sort_and_zero_trim_core
    import ssz_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_trim_enable,
    // input words
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COORD_BITS-1:0] s_point_x,
    input  logic [COORD_BITS-1:0] s_point_y,
    input  logic [SCORE_BITS-1:0] s_score_in,
    input  logic                  s_last_item,
    // result words
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COORD_BITS-1:0] m_out_x,
    output logic [COORD_BITS-1:0] m_out_y,
    output logic [SCORE_BITS-1:0] m_out_score,
    output logic                  m_out_last,
    output logic [CUT_BITS-1:0]   m_cut_count,
    output logic                  m_overflow
);

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } state_t;

    state_t                state_reg, state_next;
    logic [FILL_BITS-1:0]  fill_count_reg, fill_count_next;
    logic                  overflow_seen_reg, overflow_seen_next;
    logic                  trim_enable_reg;
    logic                  m_valid_reg, m_valid_next;
    ssz_point_t            out_point_reg, out_point_next;
    logic                  out_last_reg, out_last_next;
    logic [CUT_BITS-1:0]   cut_count_reg, cut_count_next;
    logic                  out_overflow_reg, out_overflow_next;

    ssz_ctrl_t             ctrl;
    ssz_point_t            new_point;
    ssz_point_t            cells   [CAPACITY];
    logic                  takes   [CAPACITY];
    logic                  occ     [CAPACITY];

    logic                  s_fire;
    logic                  full;
    logic                  pop;
    logic                  pop_last;

    assign new_point = '{score: s_score_in, x: s_point_x, y: s_point_y};
    assign s_ready   = (state_reg == ST_LOAD);
    assign s_fire    = s_valid && s_ready;
    assign full      = (fill_count_reg == FILL_BITS'(CAPACITY));
    assign pop       = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);

    // Head is final when alone or when trimming hits a zero right behind it
    assign pop_last  = (fill_count_reg == FILL_BITS'(1)) ||
                       (trim_enable_reg && (cells[1].score == '0));

    assign ctrl.insert    = s_fire && !full;
    assign ctrl.shift_out = pop;

    // Build the insertion chain
    for (genvar i = 0; i < CAPACITY; i++) begin : g_chain
        assign occ[i] = (FILL_BITS'(i) < fill_count_reg);
        if (i == 0) begin : g_head
            ssz_cell u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl),
                .new_point  (new_point),
                .occupied   (occ[i]),
                .left_take  (1'b0),
                .left_point (new_point),
                .right_point(cells[i+1]),
                .cell_point (cells[i]),
                .take       (takes[i])
            );
        end else if (i == CAPACITY - 1) begin : g_tail
            ssz_cell u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl),
                .new_point  (new_point),
                .occupied   (occ[i]),
                .left_take  (takes[i-1]),
                .left_point (cells[i-1]),
                .right_point(cells[i]),
                .cell_point (cells[i]),
                .take       (takes[i])
            );
        end else begin : g_mid
            ssz_cell u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl),
                .new_point  (new_point),
                .occupied   (occ[i]),
                .left_take  (takes[i-1]),
                .left_point (cells[i-1]),
                .right_point(cells[i+1]),
                .cell_point (cells[i]),
                .take       (takes[i])
            );
        end
    end

    // Sequence loading and emission
    always_comb begin
        state_next         = state_reg;
        fill_count_next    = fill_count_reg;
        overflow_seen_next = overflow_seen_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        out_point_next     = out_point_reg;
        out_last_next      = out_last_reg;
        cut_count_next     = cut_count_reg;
        out_overflow_next  = out_overflow_reg;
        case (state_reg)
            ST_LOAD: begin
                if (s_fire) begin
                    if (full) begin
                        overflow_seen_next = 1'b1;
                    end else begin
                        fill_count_next = fill_count_reg + FILL_BITS'(1);
                    end
                    if (s_last_item) begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (pop) begin
                    m_valid_next      = 1'b1;
                    out_point_next    = cells[0];
                    out_last_next     = pop_last;
                    cut_count_next    = pop_last ?
                                        CUT_BITS'(fill_count_reg - FILL_BITS'(1)) : '0;
                    out_overflow_next = overflow_seen_reg;
                    if (pop_last) begin
                        fill_count_next    = '0;
                        overflow_seen_next = 1'b0;
                        state_next         = ST_LOAD;
                    end else begin
                        fill_count_next = fill_count_reg - FILL_BITS'(1);
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Hold state and the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_LOAD;
            fill_count_reg    <= '0;
            overflow_seen_reg <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            fill_count_reg    <= fill_count_next;
            overflow_seen_reg <= overflow_seen_next;
            m_valid_reg       <= m_valid_next;
        end
        out_point_reg    <= out_point_next;
        out_last_reg     <= out_last_next;
        cut_count_reg    <= cut_count_next;
        out_overflow_reg <= out_overflow_next;
    end

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trim_enable_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            trim_enable_reg <= cfg_trim_enable;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_x     = out_point_reg.x;
    assign m_out_y     = out_point_reg.y;
    assign m_out_score = out_point_reg.score;
    assign m_out_last  = out_last_reg;
    assign m_cut_count = cut_count_reg;
    assign m_overflow  = out_overflow_reg;

    // Checks
    `SSZ_ASSERT(a_fill_bound, fill_count_reg <= FILL_BITS'(CAPACITY))
    `SSZ_ASSERT(a_head_sorted, (fill_count_reg < FILL_BITS'(2)) || !(cells[0].score < cells[1].score))
    `SSZ_ASSERT_NEXT(a_drop_flags, s_fire && full, overflow_seen_reg)
    `SSZ_ASSERT_NEXT(a_run_done, pop && pop_last, (fill_count_reg == '0) && !overflow_seen_reg && s_ready)

endmodule

// ===== hdl/ssz_cell.sv =====
// ----------------------------------------------------------------------------
// ssz_cell
// One slot of the insertion chain: holds a point, compares it with the
// incoming point and trades with its neighbors.
// ----------------------------------------------------------------------------
module ssz_cell
    import ssz_pkg::*;
(
    input  logic       aclk,
    input  ssz_ctrl_t  ctrl,
    input  ssz_point_t new_point,
    input  logic       occupied,
    input  logic       left_take,
    input  ssz_point_t left_point,
    input  ssz_point_t right_point,
    output ssz_point_t cell_point,
    output logic       take
);

    ssz_point_t point_reg;
    ssz_point_t point_next;

    // Yield this slot when empty or strictly beaten; ties stay ahead
    assign take = !occupied || (point_reg.score < new_point.score);

    // Pick the next content of the slot
    always_comb begin
        point_next = point_reg;
        if (ctrl.insert && take) begin
            point_next = left_take ? left_point : new_point;
        end else if (ctrl.shift_out) begin
            point_next = right_point;
        end
    end

    always_ff @(posedge aclk) begin
        point_reg <= point_next;
    end

    assign cell_point = point_reg;

endmodule
